// ===== rtl/per_cpu_page_free_list_allocator_macros.svh =====
// Assertion macros for the per-CPU page free-list allocator.
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PFLA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PFLA_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFLA_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFLA_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/pfla_pkg.sv =====
// Shared constants and codes for the per-CPU page free-list allocator.
`timescale 1ns / 1ps
package pfla_pkg;

  localparam int unsigned CPU_COUNT_DEF  = 8;
  localparam int unsigned NPAGES_DEF     = 4096;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CPU_ID_W   = 3;
  localparam int unsigned STOLEN_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [STOLEN_W-1:0] STEAL_RESET = 8'd32;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADADDR = 2'd1,
    ST_NOMEM   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEAL_COUNT  = 2'd0,
    CFG_REGION_START = 2'd1,
    CFG_REGION_STOP  = 2'd2
  } cfg_idx_e;

endpackage

// ===== rtl/pfla_link_mem.sv =====
// Link memory: successor page and valid flag for every page, registered read.
`timescale 1ns / 1ps
module pfla_link_mem #(
  parameter int unsigned DEPTH = pfla_pkg::NPAGES_DEF,
  parameter int unsigned DW    = $clog2(pfla_pkg::NPAGES_DEF) + 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/per_cpu_page_free_list_allocator.sv =====
// Per-CPU page free-list allocator top level with cross-CPU stealing.
// Free: busy stays low; the result strobes in the cycle after start is taken.
// Allocate from a non-empty own list: busy during S_POP, which registers the result.
// Steal: S_SCAN steps through CPU ids, own included; each page moved takes a link
// memory read (S_SCAN) then write-back (S_WB); S_POP pops the final page, if any.
// Reset empties every list at once (no clearing pass): steal_count 32, region 0..0.
`timescale 1ns / 1ps
`include "per_cpu_page_free_list_allocator_macros.svh"
module per_cpu_page_free_list_allocator #(
  parameter int unsigned CPU_COUNT  = pfla_pkg::CPU_COUNT_DEF,
  parameter int unsigned NPAGES     = pfla_pkg::NPAGES_DEF,
  parameter int unsigned PAGE_SHIFT = pfla_pkg::PAGE_SHIFT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             req_type_i,
  input  logic [pfla_pkg::CPU_ID_W-1:0]    cpu_id_i,
  input  logic [pfla_pkg::ADDR_W-1:0]      phys_addr_i,
  output logic                             done_o,
  output logic [pfla_pkg::ADDR_W-1:0]      page_addr_o,
  output logic [1:0]                       status_o,
  output logic [pfla_pkg::STOLEN_W-1:0]    pages_stolen_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pfla_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pfla_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned PW = $clog2(NPAGES);
  localparam int unsigned CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int unsigned VW = $clog2(CPU_COUNT + 1);
  localparam int unsigned SW = pfla_pkg::STOLEN_W;
  localparam int unsigned AW = pfla_pkg::ADDR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_WB
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   cpu_q, cpu_d;
  logic [SW-1:0]   left_q, left_d;
  logic [VW-1:0]   v_q, v_d;
  logic [SW-1:0]   stolen_q, stolen_d;
  logic [PW-1:0]   own_head_q, own_head_d;
  logic            own_ne_q, own_ne_d;
  logic [PW-1:0]   vic_pg_q, vic_pg_d;
  logic [PW-1:0]   pop_pg_q, pop_pg_d;
  logic [CPU_COUNT-1:0] ne_q, ne_d;
  logic [PW-1:0]   head_q [CPU_COUNT];

  logic            done_q, done_d;
  logic [AW-1:0]   page_addr_q, page_addr_d;
  logic [1:0]      status_q, status_d;
  logic [SW-1:0]   pages_stolen_q, pages_stolen_d;

  logic [SW-1:0]   steal_count_q;
  logic [AW-1:0]   region_start_q;
  logic [AW-1:0]   region_stop_q;

  logic            hd_we_a, hd_we_b;
  logic [CW-1:0]   hd_idx_a, hd_idx_b;
  logic [PW-1:0]   hd_dat_a, hd_dat_b;
  logic [CW-1:0]   hsel;
  logic [PW-1:0]   head_rd;

  logic            mem_we, mem_re;
  logic [PW-1:0]   mem_waddr, mem_raddr;
  logic [PW:0]     mem_wdata, mem_rdata;
  logic            rd_valid;
  logic [PW-1:0]   rd_link;

  logic [CW-1:0]   cpu_in;
  logic [CW-1:0]   v_cw;
  logic            cpu_ok;
  logic            free_ok;
  logic [PW-1:0]   free_pg;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign cpu_in   = CW'(cpu_id_i);
  assign v_cw     = v_q[CW-1:0];
  assign cpu_ok   = (5'(cpu_id_i) < 5'(CPU_COUNT));
  assign free_pg  = phys_addr_i[PAGE_SHIFT +: PW];
  assign free_ok  = cpu_ok
                 && (phys_addr_i[PAGE_SHIFT-1:0] == '0)
                 && (phys_addr_i >= region_start_q)
                 && (phys_addr_i < region_stop_q)
                 && ((phys_addr_i >> PAGE_SHIFT) < AW'(NPAGES));

  assign hsel     = (state_q == S_IDLE) ? cpu_in : v_cw;
  assign head_rd  = head_q[hsel];
  assign rd_valid = mem_rdata[PW];
  assign rd_link  = mem_rdata[PW-1:0];

  pfla_link_mem #(
    .DEPTH (NPAGES),
    .DW    (PW + 1)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d        = state_q;
    cpu_d          = cpu_q;
    left_d         = left_q;
    v_d            = v_q;
    stolen_d       = stolen_q;
    own_head_d     = own_head_q;
    own_ne_d       = own_ne_q;
    vic_pg_d       = vic_pg_q;
    pop_pg_d       = pop_pg_q;
    ne_d           = ne_q;
    done_d         = 1'b0;
    page_addr_d    = page_addr_q;
    status_d       = status_q;
    pages_stolen_d = pages_stolen_q;
    hd_we_a        = 1'b0;
    hd_idx_a       = cpu_q;
    hd_dat_a       = rd_link;
    hd_we_b        = 1'b0;
    hd_idx_b       = cpu_q;
    hd_dat_b       = vic_pg_q;
    mem_we         = 1'b0;
    mem_waddr      = vic_pg_q;
    mem_wdata      = {own_ne_q, own_head_q};
    mem_re         = 1'b0;
    mem_raddr      = head_rd;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cpu_d = cpu_in;
          if (req_type_i == pfla_pkg::REQ_FREE) begin
            done_d         = 1'b1;
            page_addr_d    = '0;
            pages_stolen_d = '0;
            if (free_ok) begin
              status_d     = pfla_pkg::ST_OK;
              mem_we       = 1'b1;
              mem_waddr    = free_pg;
              mem_wdata    = {ne_q[cpu_in], head_rd};
              hd_we_b      = 1'b1;
              hd_idx_b     = cpu_in;
              hd_dat_b     = free_pg;
              ne_d[cpu_in] = 1'b1;
            end else begin
              status_d = pfla_pkg::ST_BADADDR;
            end
          end else if (!cpu_ok) begin
            done_d         = 1'b1;
            page_addr_d    = '0;
            pages_stolen_d = '0;
            status_d       = pfla_pkg::ST_NOMEM;
          end else if (ne_q[cpu_in]) begin
            mem_re    = 1'b1;
            mem_raddr = head_rd;
            pop_pg_d  = head_rd;
            stolen_d  = '0;
            state_d   = S_POP;
          end else begin
            left_d   = steal_count_q;
            v_d      = '0;
            stolen_d = '0;
            own_ne_d = 1'b0;
            state_d  = S_SCAN;
          end
        end
      end
      S_POP: begin
        if (rd_valid) begin
          hd_we_a  = 1'b1;
          hd_idx_a = cpu_q;
          hd_dat_a = rd_link;
        end else begin
          ne_d[cpu_q] = 1'b0;
        end
        done_d         = 1'b1;
        page_addr_d    = AW'(AW'(pop_pg_q) << PAGE_SHIFT);
        status_d       = pfla_pkg::ST_OK;
        pages_stolen_d = stolen_q;
        state_d        = S_IDLE;
      end
      S_SCAN: begin
        if ((left_q == '0) || (v_q == VW'(CPU_COUNT))) begin
          if (own_ne_q) begin
            mem_re    = 1'b1;
            mem_raddr = own_head_q;
            pop_pg_d  = own_head_q;
            state_d   = S_POP;
          end else begin
            done_d         = 1'b1;
            page_addr_d    = '0;
            status_d       = pfla_pkg::ST_NOMEM;
            pages_stolen_d = stolen_q;
            state_d        = S_IDLE;
          end
        end else if ((v_cw == cpu_q) || !ne_q[v_cw]) begin
          v_d = VW'(v_q + 1'b1);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = head_rd;
          vic_pg_d  = head_rd;
          state_d   = S_WB;
        end
      end
      S_WB: begin
        if (rd_valid) begin
          hd_we_a  = 1'b1;
          hd_idx_a = v_cw;
          hd_dat_a = rd_link;
        end else begin
          ne_d[v_cw] = 1'b0;
        end
        mem_we      = 1'b1;
        mem_waddr   = vic_pg_q;
        mem_wdata   = {own_ne_q, own_head_q};
        hd_we_b     = 1'b1;
        hd_idx_b    = cpu_q;
        hd_dat_b    = vic_pg_q;
        ne_d[cpu_q] = 1'b1;
        own_head_d  = vic_pg_q;
        own_ne_d    = 1'b1;
        left_d      = SW'(left_q - 1'b1);
        stolen_d    = SW'(stolen_q + 1'b1);
        state_d     = S_SCAN;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      left_q         <= '0;
      v_q            <= '0;
      stolen_q       <= '0;
      own_ne_q       <= 1'b0;
      ne_q           <= '0;
      done_q         <= 1'b0;
      page_addr_q    <= '0;
      status_q       <= pfla_pkg::ST_OK;
      pages_stolen_q <= '0;
    end else begin
      state_q        <= state_d;
      left_q         <= left_d;
      v_q            <= v_d;
      stolen_q       <= stolen_d;
      own_ne_q       <= own_ne_d;
      ne_q           <= ne_d;
      done_q         <= done_d;
      page_addr_q    <= page_addr_d;
      status_q       <= status_d;
      pages_stolen_q <= pages_stolen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cpu_q      <= cpu_d;
    own_head_q <= own_head_d;
    vic_pg_q   <= vic_pg_d;
    pop_pg_q   <= pop_pg_d;
    if (hd_we_a) begin
      head_q[hd_idx_a] <= hd_dat_a;
    end
    if (hd_we_b) begin
      head_q[hd_idx_b] <= hd_dat_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steal_count_q  <= pfla_pkg::STEAL_RESET;
      region_start_q <= '0;
      region_stop_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pfla_pkg::CFG_STEAL_COUNT:  steal_count_q  <= cfg_data_i[SW-1:0];
        pfla_pkg::CFG_REGION_START: region_start_q <= cfg_data_i;
        pfla_pkg::CFG_REGION_STOP:  region_stop_q  <= cfg_data_i;
        default: begin
          steal_count_q <= steal_count_q;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign page_addr_o    = page_addr_q;
  assign status_o       = status_q;
  assign pages_stolen_o = pages_stolen_q;

  `PFLA_ASSERT(a_done_has_source, clk_i, rst_ni,
    done_o |-> ($past(start && !busy) || $past(state_q != S_IDLE)),
    "result beat without a request")
  `PFLA_ASSERT(a_wb_returns_to_scan, clk_i, rst_ni,
    (state_q == S_WB) |=> (state_q == S_SCAN), "steal write-back did not return to scan")
  `PFLA_ASSERT(a_victim_not_own, clk_i, rst_ni,
    (state_q == S_WB) |-> (v_cw != cpu_q), "stealing from own list")
  `PFLA_ASSERT(a_nomem_zero_addr, clk_i, rst_ni,
    (done_o && (status_o == pfla_pkg::ST_NOMEM)) |-> (page_addr_o == '0),
    "page address on out-of-memory")
  `PFLA_ASSERT_NORST(a_quiet_in_reset, clk_i, !rst_ni |=> !done_o, "result beat during reset")

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the per-CPU page free-list allocator: directed table, then random phases.
`timescale 1ns / 1ps
module tb;
  import pfla_pkg::*;

  localparam int unsigned CPUS   = CPU_COUNT_DEF;
  localparam int unsigned PAGES  = NPAGES_DEF;
  localparam int unsigned PSHIFT = PAGE_SHIFT_DEF;
  localparam int unsigned PG_W   = $clog2(PAGES);
  localparam logic [ADDR_W-1:0] OFFSET_MASK = (ADDR_W'(1) << PSHIFT) - 1;

  typedef struct packed {
    logic [ADDR_W-1:0]   page_addr;
    status_e             status;
    logic [STOLEN_W-1:0] stolen;
  } grant_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic                req;
    logic [CPU_ID_W-1:0] cpu;
    logic [ADDR_W-1:0]   addr;
    cfg_idx_e            idx;
    logic                typed;
    grant_t              grant;
  } row_t;

  typedef struct packed {
    logic [STOLEN_W-1:0] steal;
    logic [ADDR_W-1:0]   lo;
    logic [ADDR_W-1:0]   hi;
    logic [6:0]          gap_pct;
  } phase_t;

  localparam grant_t UNTYPED  = '{32'h0, ST_OK, 8'h0};
  localparam grant_t FREED    = '{32'h0, ST_OK, 8'h0};
  localparam grant_t BAD_FREE = '{32'h0, ST_BADADDR, 8'h0};
  localparam grant_t OOM      = '{32'h0, ST_NOMEM, 8'h0};

  localparam int unsigned ROWS   = 28;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 285;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  req_type_i = REQ_ALLOC;
  logic [CPU_ID_W-1:0]   cpu_id_i = '0;
  logic [ADDR_W-1:0]     phys_addr_i = '0;
  logic                  done_o;
  logic [ADDR_W-1:0]     page_addr_o;
  logic [1:0]            status_o;
  logic [STOLEN_W-1:0]   pages_stolen_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [PG_W-1:0]     link_next [PAGES];
  logic                link_ok [PAGES];
  logic [PG_W-1:0]     head_page [CPUS];
  bit                  list_live [CPUS];
  logic [STOLEN_W-1:0] steal_budget = STEAL_RESET;
  logic [ADDR_W-1:0]   region_lo = '0;
  logic [ADDR_W-1:0]   region_hi = '0;

  grant_t expected_grants [$];
  int     errors = 0;

  row_t plan [0:ROWS-1] = '{
    '{ROW_REQ, REQ_FREE,  3'd0, 32'h0000_1000, CFG_STEAL_COUNT,  1'b1, BAD_FREE},
    '{ROW_REQ, REQ_ALLOC, 3'd7, 32'hFFFF_FFFF, CFG_STEAL_COUNT,  1'b1, OOM},
    '{ROW_CFG, REQ_ALLOC, 3'd0, 32'h0000_2000, CFG_REGION_START, 1'b0, UNTYPED},
    '{ROW_CFG, REQ_ALLOC, 3'd0, 32'h0100_0000, CFG_REGION_STOP,  1'b0, UNTYPED},
    '{ROW_REQ, REQ_FREE,  3'd0, 32'h0000_1000, CFG_STEAL_COUNT,  1'b1, BAD_FREE},
    '{ROW_REQ, REQ_FREE,  3'd0, 32'h0000_2001, CFG_STEAL_COUNT,  1'b1, BAD_FREE},
    '{ROW_REQ, REQ_FREE,  3'd0, 32'h0100_0000, CFG_STEAL_COUNT,  1'b1, BAD_FREE},
    '{ROW_REQ, REQ_FREE,  3'd0, 32'hFFFF_F000, CFG_STEAL_COUNT,  1'b1, BAD_FREE},
    '{ROW_REQ, REQ_FREE,  3'd0, 32'h0000_2000, CFG_STEAL_COUNT,  1'b1, FREED},
    '{ROW_REQ, REQ_FREE,  3'd0, 32'h00FF_F000, CFG_STEAL_COUNT,  1'b1, FREED},
    '{ROW_REQ, REQ_ALLOC, 3'd0, 32'h0000_0000, CFG_STEAL_COUNT,  1'b1,
      '{32'h00FF_F000, ST_OK, 8'd0}},
    '{ROW_REQ, REQ_FREE,  3'd3, 32'h0000_3000, CFG_STEAL_COUNT,  1'b1, FREED},
    '{ROW_REQ, REQ_FREE,  3'd3, 32'h0000_3000, CFG_STEAL_COUNT,  1'b1, FREED},
    '{ROW_REQ, REQ_ALLOC, 3'd1, 32'h0000_0000, CFG_STEAL_COUNT,  1'b0, UNTYPED},
    '{ROW_CFG, REQ_ALLOC, 3'd0, 32'h0000_0000, CFG_STEAL_COUNT,  1'b0, UNTYPED},
    '{ROW_REQ, REQ_ALLOC, 3'd2, 32'h0000_0000, CFG_STEAL_COUNT,  1'b1, OOM},
    '{ROW_REQ, REQ_ALLOC, 3'd1, 32'h0000_0000, CFG_STEAL_COUNT,  1'b0, UNTYPED},
    '{ROW_CFG, REQ_ALLOC, 3'd0, 32'h0000_0001, CFG_STEAL_COUNT,  1'b0, UNTYPED},
    '{ROW_REQ, REQ_ALLOC, 3'd4, 32'h0000_0000, CFG_STEAL_COUNT,  1'b0, UNTYPED},
    '{ROW_CFG, REQ_ALLOC, 3'd0, 32'h0000_00FF, CFG_STEAL_COUNT,  1'b0, UNTYPED},
    '{ROW_REQ, REQ_FREE,  3'd7, 32'h00FF_E000, CFG_STEAL_COUNT,  1'b1, FREED},
    '{ROW_REQ, REQ_FREE,  3'd6, 32'h0000_5000, CFG_STEAL_COUNT,  1'b1, FREED},
    '{ROW_REQ, REQ_ALLOC, 3'd5, 32'h0000_0000, CFG_STEAL_COUNT,  1'b0, UNTYPED},
    '{ROW_REQ, REQ_ALLOC, 3'd5, 32'h0000_0000, CFG_STEAL_COUNT,  1'b0, UNTYPED},
    '{ROW_REQ, REQ_ALLOC, 3'd5, 32'h0000_0000, CFG_STEAL_COUNT,  1'b0, UNTYPED},
    '{ROW_CFG, REQ_ALLOC, 3'd0, 32'h0000_0000, CFG_REGION_START, 1'b0, UNTYPED},
    '{ROW_REQ, REQ_FREE,  3'd2, 32'h0000_0000, CFG_STEAL_COUNT,  1'b1, FREED},
    '{ROW_REQ, REQ_ALLOC, 3'd2, 32'h0000_0000, CFG_STEAL_COUNT,  1'b1, FREED}
  };

  phase_t phases [0:PHASES-1] = '{
    '{8'd32,  32'h0000_0000, 32'h0100_0000, 7'd0},
    '{8'd255, 32'h0004_0000, 32'h0008_0000, 7'd51},
    '{8'd0,   32'h0000_0000, 32'hFFFF_FFFF, 7'd0},
    '{8'd2,   32'h0000_0FFF, 32'h0002_0000, 7'd38},
    '{8'd255, 32'hFFFF_FFFF, 32'h0000_0000, 7'd0},
    '{8'd7,   32'h0000_0000, 32'h0000_8001, 7'd51}
  };

  per_cpu_page_free_list_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .cpu_id_i       (cpu_id_i),
    .phys_addr_i    (phys_addr_i),
    .done_o         (done_o),
    .page_addr_o    (page_addr_o),
    .status_o       (status_o),
    .pages_stolen_o (pages_stolen_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic void list_push(int cpu, logic [PG_W-1:0] pg);
    link_next[pg] = head_page[cpu];
    link_ok[pg]   = list_live[cpu];
    head_page[cpu] = pg;
    list_live[cpu] = 1'b1;
  endfunction

  function automatic logic [PG_W-1:0] list_pop(int cpu);
    logic [PG_W-1:0] pg;
    pg = head_page[cpu];
    if (link_ok[pg]) begin
      head_page[cpu] = link_next[pg];
    end else begin
      list_live[cpu] = 1'b0;
    end
    return pg;
  endfunction

  function automatic grant_t predict_grant(logic req, logic [CPU_ID_W-1:0] cpu,
                                           logic [ADDR_W-1:0] addr);
    grant_t              g;
    logic [STOLEN_W-1:0] budget;
    g = '{'0, ST_OK, '0};
    if (req == REQ_FREE) begin
      if (cpu >= CPUS || (addr & OFFSET_MASK) != '0 || addr < region_lo ||
          addr >= region_hi || (addr >> PSHIFT) >= PAGES) begin
        g.status = ST_BADADDR;
      end else begin
        list_push(cpu, PG_W'(addr >> PSHIFT));
      end
    end else if (cpu >= CPUS) begin
      g.status = ST_NOMEM;
    end else begin
      if (!list_live[cpu]) begin
        budget = steal_budget;
        for (int v = 0; v < CPUS; v++) begin
          if (v != cpu) begin
            while (budget != '0 && list_live[v]) begin
              list_push(cpu, list_pop(v));
              budget--;
              g.stolen++;
            end
          end
        end
      end
      if (list_live[cpu]) begin
        g.page_addr = ADDR_W'(list_pop(cpu)) << PSHIFT;
      end else begin
        g.status = ST_NOMEM;
      end
    end
    return g;
  endfunction

  task automatic issue_request(logic req, logic [CPU_ID_W-1:0] cpu, logic [ADDR_W-1:0] addr,
                               logic typed, grant_t typed_grant);
    grant_t g;
    start       <= 1'b1;
    req_type_i  <= req;
    cpu_id_i    <= cpu;
    phys_addr_i <= addr;
    do @(posedge clk_i); while (busy);
    g = predict_grant(req, cpu, addr);
    expected_grants.push_back(typed ? typed_grant : g);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    start <= 1'b0;
    wait (expected_grants.size() == 0);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_STEAL_COUNT:  steal_budget = data[STOLEN_W-1:0];
      CFG_REGION_START: region_lo = data;
      CFG_REGION_STOP:  region_hi = data;
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : grant_check
    grant_t want;
    if (rst_ni && done_o) begin
      if (expected_grants.size() == 0) begin
        $error("result beat with nothing expected: page_addr %h status %0d stolen %0d",
               page_addr_o, status_o, pages_stolen_o);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (page_addr_o !== want.page_addr) begin
          $error("page_addr: expected %h, got %h", want.page_addr, page_addr_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (pages_stolen_o !== want.stolen) begin
          $error("pages_stolen: expected %0d, got %0d", want.stolen, pages_stolen_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("per_cpu_page_free_list_allocator test failed");
    $finish;
  end

  initial begin
    longint              lo_pg;
    longint              hi_pg;
    logic                req;
    logic [CPU_ID_W-1:0] cpu;
    logic [ADDR_W-1:0]   addr;
    int unsigned         dice;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].addr);
      end else begin
        issue_request(plan[i].req, plan[i].cpu, plan[i].addr, plan[i].typed, plan[i].grant);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_STEAL_COUNT, CFG_DATA_W'(phases[p].steal));
      write_reg(CFG_REGION_START, phases[p].lo);
      write_reg(CFG_REGION_STOP, phases[p].hi);
      lo_pg = (longint'(phases[p].lo) + OFFSET_MASK) >> PSHIFT;
      hi_pg = (phases[p].hi == '0) ? -1 : (longint'(phases[p].hi) - 1) >> PSHIFT;
      if (hi_pg > PAGES - 1) hi_pg = PAGES - 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        dice = $urandom_range(99);
        cpu  = CPU_ID_W'($urandom_range(CPUS - 1));
        addr = $urandom();
        req  = REQ_FREE;
        if (dice < 40) begin
          req = REQ_ALLOC;
        end else if (dice < 85 && lo_pg <= hi_pg) begin
          addr = ADDR_W'($urandom_range(int'(hi_pg), int'(lo_pg))) << PSHIFT;
        end else begin
          case ($urandom_range(2))
            0: addr = addr & ~OFFSET_MASK;
            1: addr = (ADDR_W'($urandom_range(PAGES - 1)) << PSHIFT) |
                      ADDR_W'($urandom_range(int'(OFFSET_MASK), 1));
            default: ;
          endcase
        end
        issue_request(req, cpu, addr, 1'b0, UNTYPED);
        if ($urandom_range(99) < phases[p].gap_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(4, 1)) @(posedge clk_i);
        end
      end
    end

    start <= 1'b0;
    wait (expected_grants.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_grants.size() == 0) begin
      $display("per_cpu_page_free_list_allocator test passed");
    end else begin
      $display("per_cpu_page_free_list_allocator test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pfla_pkg.sv
rtl/pfla_link_mem.sv
rtl/per_cpu_page_free_list_allocator.sv
bench/tb.sv
